// ===== rtl/tpsk_pkg.sv =====
// Shared constants and widths for the thin-plate spline kernel.
// Used by every module in rtl; depends on nothing else.
`timescale 1ns / 1ps
package tpsk_pkg;
  localparam int COORD_W  = 24;
  localparam int DIFF_W   = 25;
  localparam int SQ_W     = 48;
  localparam int R_W      = 50;
  localparam int EXP_W    = 6;
  localparam int MANT_W   = 31;
  localparam int OUT_W    = 64;
  localparam int OUT_FRAC = 24;
  localparam logic [63:0] LN2_Q63 = 64'h58B90BFBE8E7BCD5;
  localparam logic [63:0] MAG_MAX = 64'h7FFFFFFFFFFFFFFF;
endpackage

// ===== rtl/thin_plate_spline_kernel_top.sv =====
// Top level of the thin-plate spline kernel: squared distance, normalization,
// a chain of LOG_STEPS log cells and the scaling stages. Uses tpsk_pkg, tpsk_log_cell.
//
// Usage: each input word holds two 3-D points (a_x..b_z, 24-bit signed, with
// COORD_FRAC_BITS fraction bits). Each output word holds one kernel value
// r2*ln(r2)/2, 64-bit signed with 24 fraction bits. Coincident points give 0.
// Throughput: one word per cycle while the receiver does not stall. From input
// acceptance to output valid the pipeline has four front stages (differences,
// squares, sum, normalization), the chain of log cells, one per fraction bit,
// then the signed log, two stages for the product with ln 2, two stages for
// the product with r2 and the output register with the final shift.
// The whole pipeline advances only when the output register is
// empty or being taken, so in_tready follows out_tready or an empty output.
// When the receiver stalls, the pipeline holds and no word is lost.
// Reset (rst_n low, synchronous) clears all valid flags; no word is in flight
// afterwards. The block has no configuration and no state between items.
`timescale 1ns / 1ps
module thin_plate_spline_kernel_top #(
  parameter int COORD_FRAC_BITS = 12,
  parameter int LOG_STEPS       = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z from bit 0 up, 24 bits each
  input  logic [143:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // kernel_value
  output logic [63:0]  out_tdata
);
  localparam int RW = tpsk_pkg::R_W;
  localparam int LW = LOG_STEPS + 8;
  localparam int SH = 2 * COORD_FRAC_BITS + LOG_STEPS + 1 - tpsk_pkg::OUT_FRAC;

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // Stage 1: differences.
  logic v1_r;
  logic signed [tpsk_pkg::DIFF_W-1:0] dx_r, dy_r, dz_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_tvalid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      dx_r <= {in_tdata[23], in_tdata[23:0]} - {in_tdata[95], in_tdata[95:72]};
      dy_r <= {in_tdata[47], in_tdata[47:24]} - {in_tdata[119], in_tdata[119:96]};
      dz_r <= {in_tdata[71], in_tdata[71:48]} - {in_tdata[143], in_tdata[143:120]};
    end
  end

  // Stage 2: squares.
  logic [24:0] ax, ay, az;
  assign ax = dx_r[24] ? 25'(-dx_r) : 25'(dx_r);
  assign ay = dy_r[24] ? 25'(-dy_r) : 25'(dy_r);
  assign az = dz_r[24] ? 25'(-dz_r) : 25'(dz_r);
  logic v2_r;
  logic [49:0] sx_r, sy_r, sz_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sx_r <= {25'd0, ax} * {25'd0, ax};
      sy_r <= {25'd0, ay} * {25'd0, ay};
      sz_r <= {25'd0, az} * {25'd0, az};
    end
  end

  // Stage 3: sum.
  logic v3_r;
  logic [RW-1:0] r3_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
  end
  always_ff @(posedge clk) begin
    if (en) r3_r <= sx_r + sy_r + sz_r;
  end

  // Stage 4: normalize.
  logic [tpsk_pkg::EXP_W-1:0] e_c;
  logic [RW+30:0] m_sh;
  always_comb begin
    e_c = '0;
    for (int i = 0; i < RW; i++) begin
      if (r3_r[i]) e_c = tpsk_pkg::EXP_W'(i);
    end
  end
  assign m_sh = {r3_r, 31'd0} >> (e_c + 6'd1);
  logic v4_r;
  logic [RW-1:0] r4_r;
  logic [tpsk_pkg::EXP_W-1:0] e4_r;
  logic [tpsk_pkg::MANT_W-1:0] m4_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (en) v4_r <= v3_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      r4_r <= r3_r;
      e4_r <= e_c;
      m4_r <= m_sh[tpsk_pkg::MANT_W-1:0];
    end
  end

  // Log cell chain.
  logic                        cv [LOG_STEPS+1];
  logic [RW-1:0]               cr [LOG_STEPS+1];
  logic [tpsk_pkg::EXP_W-1:0]  ce [LOG_STEPS+1];
  logic [tpsk_pkg::MANT_W-1:0] cm [LOG_STEPS+1];
  logic [LOG_STEPS-1:0]        cf [LOG_STEPS+1];
  assign cv[0] = v4_r;
  assign cr[0] = r4_r;
  assign ce[0] = e4_r;
  assign cm[0] = m4_r;
  assign cf[0] = '0;
  for (genvar g = 0; g < LOG_STEPS; g++) begin : g_cell
    tpsk_log_cell #(.FRAC_W(LOG_STEPS), .STEP(g)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .vld_in(cv[g]), .r_in(cr[g]), .e_in(ce[g]), .m_in(cm[g]), .f_in(cf[g]),
      .vld_out(cv[g+1]), .r_out(cr[g+1]), .e_out(ce[g+1]), .m_out(cm[g+1]),
      .f_out(cf[g+1])
    );
  end

  // Stage L: signed log2 magnitude.
  logic signed [LW-1:0] l_c;
  assign l_c = ($signed({{(LW-tpsk_pkg::EXP_W){1'b0}}, ce[LOG_STEPS]}
               - LW'(2 * COORD_FRAC_BITS)) <<< LOG_STEPS)
               + $signed({8'd0, cf[LOG_STEPS]});
  logic vl_r, nl_r, zl_r;
  logic [63:0] ml_r;
  logic [RW-1:0] rl_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vl_r <= 1'b0;
    else if (en) vl_r <= cv[LOG_STEPS];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      nl_r <= l_c[LW-1];
      zl_r <= (l_c == '0) || (cr[LOG_STEPS] == '0);
      ml_r <= 64'(l_c[LW-1] ? -l_c : l_c);
      rl_r <= cr[LOG_STEPS];
    end
  end

  // Stages P1..P2: P = (|L| * LN2) >> 63, four 32x32 partial products.
  logic vp1_r, np1_r, zp1_r;
  logic [RW-1:0] rp1_r;
  logic [63:0] p00_r, p01_r, p10_r, p11_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vp1_r <= 1'b0;
    else if (en) vp1_r <= vl_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      np1_r <= nl_r; zp1_r <= zl_r; rp1_r <= rl_r;
      p00_r <= ml_r[31:0]  * tpsk_pkg::LN2_Q63[31:0];
      p01_r <= ml_r[31:0]  * tpsk_pkg::LN2_Q63[63:32];
      p10_r <= ml_r[63:32] * tpsk_pkg::LN2_Q63[31:0];
      p11_r <= ml_r[63:32] * tpsk_pkg::LN2_Q63[63:32];
    end
  end
  logic [127:0] pa_c;
  assign pa_c = {64'd0, p00_r} + ({64'd0, p01_r} << 32) + ({64'd0, p10_r} << 32)
              + ({p11_r, 64'd0});
  logic vp2_r, np2_r, zp2_r;
  logic [RW-1:0] rp2_r;
  logic [63:0] pv_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vp2_r <= 1'b0;
    else if (en) vp2_r <= vp1_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      np2_r <= np1_r; zp2_r <= zp1_r; rp2_r <= rp1_r;
      pv_r  <= pa_c[126:63];
    end
  end

  // Stage K1: R * P partial products (R is 50 bits, P is at most 63 bits).
  logic vk1_r, nk1_r, zk1_r;
  logic [63:0] k00_r, k01_r, k10_r, k11_r;
  logic [63:0] rpad;
  assign rpad = {14'd0, rp2_r};
  always_ff @(posedge clk) begin
    if (!rst_n) vk1_r <= 1'b0;
    else if (en) vk1_r <= vp2_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      nk1_r <= np2_r; zk1_r <= zp2_r;
      k00_r <= rpad[31:0]  * pv_r[31:0];
      k01_r <= rpad[31:0]  * pv_r[63:32];
      k10_r <= rpad[63:32] * pv_r[31:0];
      k11_r <= rpad[63:32] * pv_r[63:32];
    end
  end
  logic [127:0] ka_c;
  assign ka_c = {64'd0, k00_r} + ({64'd0, k01_r} << 32) + ({64'd0, k10_r} << 32)
              + ({k11_r, 64'd0});
  logic vk2_r, nk2_r, zk2_r;
  logic [127:0] kp_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vk2_r <= 1'b0;
    else if (en) vk2_r <= vk1_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      nk2_r <= nk1_r; zk2_r <= zk1_r; kp_r <= ka_c;
    end
  end

  // Final shift with saturation.
  logic [191:0] wide;
  logic [191:0] shv;
  logic [63:0]  mag_c;
  always_comb begin
    wide = {64'd0, kp_r};
    if (SH >= 0) shv = wide >> SH;
    else         shv = wide << (-SH);
    if (shv[191:63] != '0) mag_c = tpsk_pkg::MAG_MAX;
    else                   mag_c = shv[63:0];
  end
  logic [63:0] out_tdata_r;
  logic        out_tvalid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid_r <= 1'b0;
    else if (en) out_tvalid_r <= vk2_r;
  end
  always_ff @(posedge clk) begin
    if (en) out_tdata_r <= zk2_r ? 64'd0 : (nk2_r ? 64'(-mag_c) : mag_c);
  end
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output side");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    en && vk2_r && zk2_r |=> out_tdata == 64'd0)
    else $error("zero distance did not give zero");
endmodule

// ===== rtl/tpsk_log_cell.sv =====
// One step of the log2 fraction chain: squares the mantissa and emits one bit.
// Also carries r2 and the exponent along with the item. Depends on tpsk_pkg.
`timescale 1ns / 1ps
module tpsk_log_cell #(
  parameter int FRAC_W = 32,
  parameter int STEP   = 0
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            vld_in,
  input  logic [tpsk_pkg::R_W-1:0]        r_in,
  input  logic [tpsk_pkg::EXP_W-1:0]      e_in,
  input  logic [tpsk_pkg::MANT_W-1:0]     m_in,
  input  logic [FRAC_W-1:0]               f_in,
  output logic                            vld_out,
  output logic [tpsk_pkg::R_W-1:0]        r_out,
  output logic [tpsk_pkg::EXP_W-1:0]      e_out,
  output logic [tpsk_pkg::MANT_W-1:0]     m_out,
  output logic [FRAC_W-1:0]               f_out
);
  logic [61:0] q;
  logic        bit_one;
  logic [tpsk_pkg::MANT_W-1:0] m_nxt;
  logic [FRAC_W-1:0] f_nxt;
  logic vld_r;
  logic [tpsk_pkg::R_W-1:0] r_r;
  logic [tpsk_pkg::EXP_W-1:0] e_r;
  logic [tpsk_pkg::MANT_W-1:0] m_r;
  logic [FRAC_W-1:0] f_r;

  assign q       = {31'd0, m_in} * {31'd0, m_in};
  assign bit_one = q[61];
  assign m_nxt   = bit_one ? q[61:31] : q[60:30];
  always_comb begin
    f_nxt = f_in;
    f_nxt[FRAC_W-1-STEP] = bit_one;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      r_r <= r_in;
      e_r <= e_in;
      m_r <= m_nxt;
      f_r <= f_nxt;
    end
  end
  assign vld_out = vld_r;
  assign r_out   = r_r;
  assign e_out   = e_r;
  assign m_out   = m_r;
  assign f_out   = f_r;
endmodule
